// ===== rtl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int COORD_W = 12;
    localparam int STEP_W  = 24;
    localparam int PROD_W  = COORD_W + STEP_W;
    localparam int SIZE_W  = 9;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 4 * CHAN_W;
    localparam int NBANK   = 4;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_STEP_X     = 2'd2,
        REG_STEP_Y     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] src_width;
        logic [SIZE_W-1:0] src_height;
        logic [STEP_W-1:0] step_x;
        logic [STEP_W-1:0] step_y;
    } cfg_t;

    // bank parity of each neighbor
    typedef struct packed {
        logic x0p;
        logic x1p;
        logic y0p;
        logic y1p;
    } sel_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  alpha;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  red;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } res_t;

endpackage

// ===== rtl/bis_ram.sv =====
// ----------------------------------------------------------------------------
// bis_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bis_cfg.sv =====
// ----------------------------------------------------------------------------
// bis_cfg
// APB register file: source size and inverse zoom steps.
// ----------------------------------------------------------------------------
module bis_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bis_pkg::cfg_t cfg
);

    bis_pkg::cfg_t     cfg_reg;
    bis_pkg::reg_idx_t idx;
    logic              wr;

    assign idx    = bis_pkg::reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width  <= bis_pkg::SIZE_RESET;
            cfg_reg.src_height <= bis_pkg::SIZE_RESET;
            cfg_reg.step_x     <= bis_pkg::STEP_RESET;
            cfg_reg.step_y     <= bis_pkg::STEP_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                bis_pkg::REG_SRC_WIDTH:  cfg_reg.src_width  <= pwdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_SRC_HEIGHT: cfg_reg.src_height <= pwdata[bis_pkg::SIZE_W-1:0];
                bis_pkg::REG_STEP_X:     cfg_reg.step_x     <= pwdata[bis_pkg::STEP_W-1:0];
                bis_pkg::REG_STEP_Y:     cfg_reg.step_y     <= pwdata[bis_pkg::STEP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bis_pkg::REG_SRC_WIDTH:  prdata = 32'(cfg_reg.src_width);
            bis_pkg::REG_SRC_HEIGHT: prdata = 32'(cfg_reg.src_height);
            bis_pkg::REG_STEP_X:     prdata = 32'(cfg_reg.step_x);
            bis_pkg::REG_STEP_Y:     prdata = 32'(cfg_reg.step_y);
        endcase
    end

endmodule

// ===== rtl/bis_blend.sv =====
// ----------------------------------------------------------------------------
// bis_blend
// Weight products, per-channel weighting and final sum of four neighbors.
// ----------------------------------------------------------------------------
module bis_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [bis_pkg::COORD_W-1:0]    in_col,
    input  logic [bis_pkg::COORD_W-1:0]    in_row,
    input  logic [FRAC_BITS-1:0]           fx,
    input  logic [FRAC_BITS-1:0]           fy,
    input  bis_pkg::sel_t                  sel,
    input  logic [bis_pkg::PIX_W-1:0]      bank_data [bis_pkg::NBANK],
    output logic                           out_valid,
    output bis_pkg::res_t                  res
);

    localparam int WPW = 2 * FRAC_BITS + 2;
    localparam int PPW = WPW + bis_pkg::CHAN_W;
    localparam int SW  = PPW + 2;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [FRAC_BITS:0] wx0, wx1, wy0, wy1;
    logic [WPW-1:0]     wt_reg [4];   // 00, 01, 10, 11
    logic [bis_pkg::PIX_W-1:0] px_reg [4];
    logic [bis_pkg::COORD_W-1:0] cola_reg, rowa_reg, colb_reg, rowb_reg;
    logic va_reg, vb_reg;
    logic [PPW-1:0] prod_reg [4][4];  // [channel][neighbor]
    logic [SW-1:0]  sum [4];

    assign wx1 = {1'b0, fx};
    assign wy1 = {1'b0, fy};
    assign wx0 = ONE - wx1;
    assign wy0 = ONE - wy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wt_reg[0] <= WPW'(wx0) * WPW'(wy0);
            wt_reg[1] <= WPW'(wx0) * WPW'(wy1);
            wt_reg[2] <= WPW'(wx1) * WPW'(wy0);
            wt_reg[3] <= WPW'(wx1) * WPW'(wy1);
            px_reg[0] <= bank_data[{sel.y0p, sel.x0p}];
            px_reg[1] <= bank_data[{sel.y1p, sel.x0p}];
            px_reg[2] <= bank_data[{sel.y0p, sel.x1p}];
            px_reg[3] <= bank_data[{sel.y1p, sel.x1p}];
            cola_reg  <= in_col;
            rowa_reg  <= in_row;
            colb_reg  <= cola_reg;
            rowb_reg  <= rowa_reg;
            for (int c = 0; c < 4; c++)
            begin
                for (int n = 0; n < 4; n++)
                begin
                    prod_reg[c][n] <= PPW'(px_reg[n][c*bis_pkg::CHAN_W +: bis_pkg::CHAN_W])
                                    * PPW'(wt_reg[n]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            sum[c] = SW'(prod_reg[c][0]) + SW'(prod_reg[c][1])
                   + SW'(prod_reg[c][2]) + SW'(prod_reg[c][3]);
        end
    end

    assign out_valid = vb_reg;
    assign res.col   = colb_reg;
    assign res.row   = rowb_reg;
    assign res.red   = sum[0][2*FRAC_BITS +: bis_pkg::CHAN_W];
    assign res.green = sum[1][2*FRAC_BITS +: bis_pkg::CHAN_W];
    assign res.blue  = sum[2][2*FRAC_BITS +: bis_pkg::CHAN_W];
    assign res.alpha = sum[3][2*FRAC_BITS +: bis_pkg::CHAN_W];

endmodule

// ===== rtl/bilinear_image_scaler_unit.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit
// RGBA8 source pixel store with a bilinear resampling pipeline.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while not stalled, a pixel write or
// an interpolate request; a request passes stage 1, stage 2 and the blend
// registers into the output register. Throughput is one word per clock
// when not stalled: the pixel store is split into four banks by column and
// row parity, so the four neighbors of any sample come from four separate
// read ports in a single cycle. Writes and reads both touch the banks in
// the same stage, so a pixel written by one word is seen by every later
// request. The pipeline stalls only when the output register is full and not taken.
// Store contents are undefined until written; there is no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // col, row, in_red, in_green, in_blue, in_alpha
    input  logic        s_tuser,   // func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_col, out_row, out_red, out_green, out_blue, out_alpha
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW  = bis_pkg::COORD_W;
    localparam int PW  = bis_pkg::PROD_W;
    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int HX  = (MAX_WIDTH + 1) / 2;
    localparam int HY  = (MAX_HEIGHT + 1) / 2;
    localparam int XHW = (HX > 1) ? $clog2(HX) : 1;
    localparam int YHW = (HY > 1) ? $clog2(HY) : 1;
    localparam int DEPTH = HX * HY;
    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bis_pkg::cfg_t cfg;

    bis_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective image size: zero acts as one, clipped to the store
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        priority if (cfg.src_width == '0)
            w_eff = WW'(1);
        else if (32'(cfg.src_width) > MAX_WIDTH)
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(cfg.src_width);
        priority if (cfg.src_height == '0)
            h_eff = HW'(1);
        else if (32'(cfg.src_height) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(cfg.src_height);
    end

    // pipeline advance: stall only while a result blocks the output
    logic en;
    logic blend_v;
    logic m_valid_reg;
    bis_pkg::res_t blend_res, res_reg;

    assign en       = !blend_v || !m_valid_reg || m_tready;
    assign s_tready = en;

    // stage 1: register the word and the coordinate products
    logic              v1_reg, func1_reg, wok1_reg;
    logic [CW-1:0]     col1_reg, row1_reg;
    logic [31:0]       pix1_reg;
    logic [PW-1:0]     px1_reg, py1_reg;
    logic [CW-1:0]     s_col, s_row;

    assign s_col = s_tdata[11:0];
    assign s_row = s_tdata[23:12];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= s_tuser;
            col1_reg  <= s_col;
            row1_reg  <= s_row;
            pix1_reg  <= s_tdata[55:24];
            wok1_reg  <= (32'(s_col) < 32'(w_eff)) && (32'(s_row) < 32'(h_eff));
            px1_reg   <= PW'(s_col) * PW'(cfg.step_x);
            py1_reg   <= PW'(s_row) * PW'(cfg.step_y);
        end
    end

    // stage 2: integer part, edge clamp, bank addressing
    logic [WW-1:0]        w_lim;
    logic [HW-1:0]        h_lim;
    logic [XW-1:0]        x0, x1, xe, xo;
    logic [YW-1:0]        y0, y1, ye, yo;
    logic [FRAC_BITS-1:0] fx, fy;

    assign w_lim = w_eff - WW'(1);
    assign h_lim = h_eff - HW'(1);

    always_comb
    begin
        if ((px1_reg >> FRAC_BITS) >= PW'(w_lim))
        begin
            x0 = XW'(w_lim);
            x1 = XW'(w_lim);
            fx = '0;
        end
        else
        begin
            x0 = XW'(px1_reg >> FRAC_BITS);
            x1 = x0 + XW'(1);
            fx = px1_reg[FRAC_BITS-1:0];
        end
        if ((py1_reg >> FRAC_BITS) >= PW'(h_lim))
        begin
            y0 = YW'(h_lim);
            y1 = YW'(h_lim);
            fy = '0;
        end
        else
        begin
            y0 = YW'(py1_reg >> FRAC_BITS);
            y1 = y0 + YW'(1);
            fy = py1_reg[FRAC_BITS-1:0];
        end
        // the even and the odd column (row) among the two neighbors
        xe = x0[0] ? x1 : x0;
        xo = x0[0] ? x0 : x1;
        ye = y0[0] ? y1 : y0;
        yo = y0[0] ? y0 : y1;
    end

    logic [XW-1:0] wcol;
    logic [YW-1:0] wrow;
    logic [AW-1:0] waddr;
    logic          wr_go;

    assign wcol  = XW'(col1_reg);
    assign wrow  = YW'(row1_reg);
    assign waddr = AW'(32'(YHW'(wrow >> 1)) * HX + 32'(XHW'(wcol >> 1)));
    assign wr_go = en && v1_reg && !func1_reg && wok1_reg;

    logic [bis_pkg::PIX_W-1:0] bank_data [bis_pkg::NBANK];

    for (genvar b = 0; b < bis_pkg::NBANK; b++)
    begin : g_bank
        logic [XW-1:0] rx;
        logic [YW-1:0] ry;
        logic [AW-1:0] raddr;
        logic          we;

        // bank index: bit 1 row parity, bit 0 column parity
        assign rx    = (b % 2 == 1) ? xo : xe;
        assign ry    = (b / 2 == 1) ? yo : ye;
        assign raddr = AW'(32'(YHW'(ry >> 1)) * HX + 32'(XHW'(rx >> 1)));
        assign we    = wr_go && ({wrow[0], wcol[0]} == 2'(b));

        bis_ram #(
            .WIDTH (bis_pkg::PIX_W),
            .DEPTH (DEPTH),
            .AW    (AW)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (pix1_reg),
            .re    (en),
            .raddr (raddr),
            .rdata (bank_data[b])
        );
    end

    logic                 v2_reg;
    logic [CW-1:0]        col2_reg, row2_reg;
    logic [FRAC_BITS-1:0] fx2_reg, fy2_reg;
    bis_pkg::sel_t        sel2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg && func1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col2_reg     <= col1_reg;
            row2_reg     <= row1_reg;
            fx2_reg      <= fx;
            fy2_reg      <= fy;
            sel2_reg.x0p <= x0[0];
            sel2_reg.x1p <= x1[0];
            sel2_reg.y0p <= y0[0];
            sel2_reg.y1p <= y1[0];
        end
    end

    // stages 3 and 4: weights, products; sum lands in the output register
    bis_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_col    (col2_reg),
        .in_row    (row2_reg),
        .fx        (fx2_reg),
        .fy        (fy2_reg),
        .sel       (sel2_reg),
        .bank_data (bank_data),
        .out_valid (blend_v),
        .res       (blend_res)
    );

    logic m_valid_next;

    always_comb
    begin
        priority if (en && blend_v)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && blend_v)
        begin
            res_reg <= blend_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.alpha, res_reg.blue, res_reg.green, res_reg.red,
                       res_reg.row, res_reg.col};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bilinear image scaler.
// ----------------------------------------------------------------------------
// Loads small source images through the pixel-write word, then requests
// interpolated pixels and compares each result against an in-bench
// fixed-point model of the scaler. Runs several register settings,
// including the size and step extremes, with random idle on both streams.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 256;
    localparam int MAXH = 256;
    localparam int FRAC = 16;
    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_INTERP = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bilinear_image_scaler_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // one input word, fields as the block sees them
    typedef struct {
        logic        func;
        logic [11:0] col;
        logic [11:0] row;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } pix_word_t;

    // model state
    logic [31:0] pixel_mem [int];
    logic [8:0]  width_reg;
    logic [8:0]  height_reg;
    logic [23:0] stepx_reg;
    logic [23:0] stepy_reg;

    bis_pkg::res_t pending_pixels[$];
    int   mismatches;
    int   watchdog;
    bit   timed_out;

    // currently loaded image extent, as set by load_image
    int   img_w;
    int   img_h;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int clamp_size(logic [8:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // source index pair and fraction along one axis
    function automatic void map_coord(logic [11:0] dest, logic [23:0] step, int size,
                                      output int i0, output int i1,
                                      output longint unsigned frac);
        longint unsigned c;
        longint unsigned ip;
        c  = longint'(dest) * longint'(step);
        ip = c >> FRAC;
        if (ip >= size - 1)
        begin
            i0 = size - 1;
            i1 = size - 1;
            frac = 0;
        end
        else
        begin
            i0 = int'(ip);
            i1 = int'(ip) + 1;
            frac = c & ((64'd1 << FRAC) - 1);
        end
    endfunction

    function automatic logic [31:0] stored_pixel(int x, int y);
        int a;
        a = y * MAXW + x;
        return pixel_mem.exists(a) ? pixel_mem[a] : 32'h0;
    endfunction

    // update store or compute the resampled pixel
    function automatic bit resample(pix_word_t w, output bis_pkg::res_t r);
        int x0, x1, y0, y1, wd, ht;
        longint unsigned fx, fy, one, w00, w01, w10, w11, acc;
        logic [31:0] p00, p01, p10, p11;
        logic [7:0]  ch [4];
        wd = clamp_size(width_reg, MAXW);
        ht = clamp_size(height_reg, MAXH);
        r = '0;
        if (w.func == FUNC_WRITE)
        begin
            if (w.col < wd && w.row < ht)
                pixel_mem[w.row * MAXW + w.col] = {w.alpha, w.blue, w.green, w.red};
            return 0;
        end
        map_coord(w.col, stepx_reg, wd, x0, x1, fx);
        map_coord(w.row, stepy_reg, ht, y0, y1, fy);
        p00 = stored_pixel(x0, y0);
        p01 = stored_pixel(x0, y1);
        p10 = stored_pixel(x1, y0);
        p11 = stored_pixel(x1, y1);
        one = 64'd1 << FRAC;
        w00 = (one - fx) * (one - fy);
        w01 = (one - fx) * fy;
        w10 = fx * (one - fy);
        w11 = fx * fy;
        for (int k = 0; k < 4; k++)
        begin
            acc = p00[k*8 +: 8] * w00 + p01[k*8 +: 8] * w01
                + p10[k*8 +: 8] * w10 + p11[k*8 +: 8] * w11;
            ch[k] = 8'((acc >> (2 * FRAC)) & 64'hFF);
        end
        r.col = w.col;
        r.row = w.row;
        r.red = ch[0];
        r.green = ch[1];
        r.blue = ch[2];
        r.alpha = ch[3];
        return 1;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // setup and access phases, then the bus is released before returning
    task automatic apb_write(bis_pkg::reg_idx_t idx, logic [31:0] val);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            bis_pkg::REG_SRC_WIDTH:  width_reg  = val[8:0];
            bis_pkg::REG_SRC_HEIGHT: height_reg = val[8:0];
            bis_pkg::REG_STEP_X:     stepx_reg  = val[23:0];
            bis_pkg::REG_STEP_Y:     stepy_reg  = val[23:0];
        endcase
        @(posedge clk);
    endtask

    // push one word; queue the expected pixel once accepted
    task automatic send_word(pix_word_t w, bit hold_gap = 1);
        bis_pkg::res_t r;
        int gap;
        gap = 0;
        if (hold_gap && $urandom_range(0, 3) != 0)
            gap = $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.func;
        s_tdata  <= {w.alpha, w.blue, w.green, w.red, w.row, w.col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (resample(w, r))
            pending_pixels.push_back(r);
    endtask

    // wait until every result is in, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0 && !timed_out)
            @(posedge clk);
        idle_cycles(DRAIN_CYCLES);
    endtask

    function automatic pix_word_t mk_word(logic f, int c, int r, logic [31:0] px);
        pix_word_t w;
        w.func = f;
        w.col = 12'(c);
        w.row = 12'(r);
        {w.alpha, w.blue, w.green, w.red} = px;
        return w;
    endfunction

    // fill the image area width x height with random pixels
    task automatic load_image(int wd, int ht);
        for (int y = 0; y < ht; y++)
            for (int x = 0; x < wd; x++)
                send_word(mk_word(FUNC_WRITE, x, y, $urandom()), $urandom_range(0, 7) == 0);
        img_w = wd;
        img_h = ht;
    endtask

    // random interpolate word; dest range kept small mostly
    function automatic pix_word_t rand_request();
        int c, r;
        if ($urandom_range(0, 9) == 0)
        begin
            c = $urandom_range(0, 4095);
            r = $urandom_range(0, 4095);
        end
        else
        begin
            c = $urandom_range(0, 40);
            r = $urandom_range(0, 40);
        end
        return mk_word(FUNC_INTERP, c, r, $urandom());
    endfunction

    // result checker; sink stalls drawn per word
    initial
    begin
        int stall;
        bis_pkg::res_t got;
        bis_pkg::res_t want;
        mismatches = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            got = bis_pkg::res_t'(m_tdata);
            if (pending_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", m_tdata);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either stream and no APB access
    initial
    begin
        watchdog = 0;
        timed_out = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                watchdog = 0;
            else
                watchdog++;
            if (watchdog >= WATCHDOG_LIMIT)
            begin
                timed_out = 1;
                $display("FAILURE");
                $finish;
            end
        end
    end

    // directed table: expected value typed only where obvious, else has_exp clear -> predictor
    typedef struct {
        pix_word_t w;
        bit        has_exp;
        logic [31:0] exp_px;
    } dir_row_t;

    initial
    begin
        dir_row_t table_rows[$];
        dir_row_t rw;
        bis_pkg::res_t r;
        int sent;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        width_reg  = 9'd256;
        height_reg = 9'd256;
        stepx_reg  = 24'd65536;
        stepy_reg  = 24'd65536;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- phase 1: small 4x3 image, unit step after reset, directed rows ---
        apb_write(bis_pkg::REG_SRC_WIDTH, 32'd4);
        apb_write(bis_pkg::REG_SRC_HEIGHT, 32'd3);
        rw.has_exp = 0; rw.exp_px = '0;
        // corner extremes of the pixel value
        rw.w = mk_word(FUNC_WRITE, 0, 0, 32'hFFFF_FFFF); table_rows.push_back(rw);
        rw.w = mk_word(FUNC_WRITE, 3, 2, 32'h0000_0000); table_rows.push_back(rw);
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 4; x++)
                if (!(x == 0 && y == 0) && !(x == 3 && y == 2))
                begin
                    rw.w = mk_word(FUNC_WRITE, x, y, $urandom());
                    table_rows.push_back(rw);
                end
        // writes outside the image are dropped
        rw.w = mk_word(FUNC_WRITE, 4, 0, 32'h1234_5678); table_rows.push_back(rw);
        rw.w = mk_word(FUNC_WRITE, 0, 3, 32'h1234_5678); table_rows.push_back(rw);
        rw.w = mk_word(FUNC_WRITE, 4095, 4095, 32'h8765_4321); table_rows.push_back(rw);
        // unit step: exact pixel reads
        rw.has_exp = 1; rw.exp_px = 32'hFFFF_FFFF;
        rw.w = mk_word(FUNC_INTERP, 0, 0, 32'hFFFF_FFFF); table_rows.push_back(rw);
        rw.exp_px = 32'h0;
        rw.w = mk_word(FUNC_INTERP, 3, 2, 32'h0); table_rows.push_back(rw);
        // clamped edge at the far destination
        rw.w = mk_word(FUNC_INTERP, 4095, 4095, 32'h0); table_rows.push_back(rw);
        rw.has_exp = 0;
        rw.w = mk_word(FUNC_INTERP, 1, 1, 32'h0); table_rows.push_back(rw);
        rw.w = mk_word(FUNC_INTERP, 2, 4095, 32'h0); table_rows.push_back(rw);

        foreach (table_rows[i])
        begin
            send_word(table_rows[i].w);
            if (table_rows[i].has_exp && table_rows[i].w.func == FUNC_INTERP)
            begin
                r = pending_pixels[$];
                if ({r.alpha, r.blue, r.green, r.red} !== table_rows[i].exp_px)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d: expected %h predicted %h", i,
                                 table_rows[i].exp_px, {r.alpha, r.blue, r.green, r.red});
                end
            end
        end
        // half step in x gives true blends; zero step in y maps all to source row 0
        wait_drained();
        apb_write(bis_pkg::REG_STEP_X, 32'h8000);
        apb_write(bis_pkg::REG_STEP_Y, 32'h0);
        for (int k = 0; k < 6; k++)
            send_word(mk_word(FUNC_INTERP, k, k, 32'h0));

        // sender pauses until every result has come
        wait_drained();

        // --- random phases over several settings ---
        sent = 0;
        for (int ph = 0; ph < 7; ph++)
        begin
            int wd, ht;
            logic [23:0] sx, sy;
            case (ph)
                0: begin wd = 1;  ht = 1;  sx = 24'hFFFFFF; sy = 24'd1;     end
                1: begin wd = 2;  ht = 2;  sx = 24'd1;      sy = 24'hFFFFFF; end
                2: begin wd = 7;  ht = 5;  sx = 24'h6000;   sy = 24'h3000;  end
                3: begin wd = 16; ht = 9;  sx = 24'h1_8000; sy = 24'h0_5555; end
                4: begin wd = 5;  ht = 12; sx = 24'h0;      sy = 24'h0_2345; end
                5: begin wd = 11; ht = 3;  sx = 24'h2_4000; sy = 24'h0_C000; end
                default:
                begin
                    wd = $urandom_range(2, 12); ht = $urandom_range(2, 12);
                    sx = $urandom_range(1, 24'h3FFFF); sy = $urandom_range(1, 24'h3FFFF);
                end
            endcase
            wait_drained();
            // out-of-range register values act as 1 or as the maximum
            if (ph == 0)
                apb_write(bis_pkg::REG_SRC_WIDTH, 32'h0);
            else
                apb_write(bis_pkg::REG_SRC_WIDTH, 32'(wd));
            apb_write(bis_pkg::REG_SRC_HEIGHT, (ph == 0) ? 32'h1FF_0001 : 32'(ht));
            apb_write(bis_pkg::REG_STEP_X, {8'hA5, sx});
            apb_write(bis_pkg::REG_STEP_Y, 32'(sy));
            load_image(wd, ht);
            sent += wd * ht;
            for (int k = 0; k < 65; k++)
            begin
                pix_word_t w;
                if ($urandom_range(0, 4) == 0)
                    // rewrite in range, or a stray write outside (ignored)
                    w = mk_word(FUNC_WRITE,
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(0, wd - 1),
                                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                            : $urandom_range(0, ht - 1),
                                $urandom());
                else
                    w = rand_request();
                // a stretch with no gaps in each phase
                send_word(w, k < 20 ? 0 : 1);
                sent++;
            end
        end

        // phase at full size: width/height 256 register extremes
        wait_drained();
        apb_write(bis_pkg::REG_SRC_WIDTH, 32'd256);
        apb_write(bis_pkg::REG_SRC_HEIGHT, 32'd256);
        apb_write(bis_pkg::REG_STEP_X, 32'd65536);
        apb_write(bis_pkg::REG_STEP_Y, 32'd65536);
        send_word(mk_word(FUNC_WRITE, 255, 255, 32'hA5C3_3C5A));
        send_word(mk_word(FUNC_WRITE, 255, 254, 32'h0102_0304));
        send_word(mk_word(FUNC_INTERP, 255, 255, 32'h0));
        send_word(mk_word(FUNC_INTERP, 4095, 254, 32'h0));

        wait_drained();
        if (mismatches == 0 && pending_pixels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
